// ===== design/bcu_pkg.sv =====
package bcu_pkg;
  localparam int DIV_W  = 32;
  localparam int SIDE_W = 64;

  localparam logic [1:0] REG_CAL_FIRST  = 2'd0;
  localparam logic [1:0] REG_CAL_SECOND = 2'd1;
  localparam logic [1:0] REG_CAL_LAST   = 2'd2;
  localparam logic [1:0] REG_OSS        = 2'd3;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input int s);
    return $unsigned($signed(x) >>> s);
  endfunction
endpackage

// ===== design/bcu_udiv.sv =====
module bcu_udiv import bcu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [DIV_W-1:0]  quotient,
  output logic [SIDE_W-1:0] side_out
);
  logic [DIV_W-1:0]  rem  [DIV_W+1];
  logic [DIV_W-1:0]  num  [DIV_W+1];
  logic [DIV_W-1:0]  dvs  [DIV_W+1];
  logic [SIDE_W-1:0] side [DIV_W+1];
  logic              vld  [DIV_W+1];

  assign rem[0]  = '0;
  assign num[0]  = dividend;
  assign dvs[0]  = divisor;
  assign side[0] = side_in;
  assign vld[0]  = in_valid;

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic [DIV_W:0] trial;
    logic           ge;
    assign trial = {rem[k], num[k][DIV_W-1]};
    assign ge    = trial >= {1'b0, dvs[k]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        rem[k+1]  <= ge ? DIV_W'(trial - {1'b0, dvs[k]}) : trial[DIV_W-1:0];
        num[k+1]  <= {num[k][DIV_W-2:0], ge};
        dvs[k+1]  <= dvs[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[DIV_W];
  assign quotient  = num[DIV_W];
  assign side_out  = side[DIV_W];
endmodule

// ===== design/barometric_compensation_unit.sv =====
// Barometric compensation: raw temperature and pressure words in, temperature in
// 0.1 degC and pressure in Pa out, following the 32-bit integer datasheet chain.
// One word is accepted per cycle unless m_tready stalls the output; the pipeline runs
// through two 32-stage bit-per-stage dividers plus the multiply stages. A zero divisor
// sets divide_fault with zero results. Calibration registers: 0 AC1..AC4, 1 AC5,AC6,
// B1,B2, 2 MC,MD, 3 oversampling; write them only while the pipeline is empty.
module barometric_compensation_unit import bcu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // raw_temperature[15:0], pressure_msb[23:16], pressure_lsb[31:24], pressure_xlsb[39:32]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // temperature_tenths[15:0], pressure_pa[35:16], divide_fault[36], zero[39:37]
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [63:0] cal_first_four, cal_second_four;
  logic [31:0] cal_last_two;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_first_four  <= '0;
      cal_second_four <= '0;
      cal_last_two    <= '0;
      oss             <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_FIRST:  cal_first_four  <= cfg_data;
        REG_CAL_SECOND: cal_second_four <= cfg_data;
        REG_CAL_LAST:   cal_last_two    <= cfg_data[31:0];
        REG_OSS:        oss             <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = sx16(cal_first_four[63:48]);
  assign ac2 = sx16(cal_first_four[47:32]);
  assign ac3 = sx16(cal_first_four[31:16]);
  assign ac4 = {16'd0, cal_first_four[15:0]};
  assign ac5 = {16'd0, cal_second_four[63:48]};
  assign ac6 = {16'd0, cal_second_four[47:32]};
  assign b1  = sx16(cal_second_four[31:16]);
  assign b2  = sx16(cal_second_four[15:0]);
  assign mc  = sx16(cal_last_two[31:16]);
  assign md  = sx16(cal_last_two[15:0]);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [23:0] up_raw;
  assign up_raw = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};

  // stage A
  logic        va;
  logic [31:0] a_diff, a_up;
  // stage B
  logic        vb;
  logic [31:0] b_prod, b_up;
  // stage C
  logic        vc, c_neg, c_fault;
  logic [31:0] c_x1, c_ma, c_mb, c_up;
  logic [31:0] cx1, cdiv, cnum;
  assign cx1  = asr(b_prod, 15);
  assign cdiv = cx1 + md;
  assign cnum = mc << 11;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
      vb <= va;
      vc <= vb;
    end
    if (en) begin
      a_diff  <= {16'd0, s_tdata[15:0]} - ac6;
      a_up    <= {8'd0, up_raw} >> (4'd8 - {2'd0, oss});
      b_prod  <= 32'(a_diff * ac5);
      b_up    <= a_up;
      c_x1    <= cx1;
      c_fault <= cdiv == 32'd0;
      c_neg   <= cnum[31] ^ cdiv[31];
      c_ma    <= cnum[31] ? 32'd0 - cnum : cnum;
      c_mb    <= cdiv[31] ? 32'd0 - cdiv : cdiv;
      c_up    <= b_up;
    end
  end

  logic              d1_v;
  logic [31:0]       d1_q;
  logic [SIDE_W-1:0] d1_side;

  bcu_udiv u_div_t (
    .clk(clk), .rst(rst), .en(en), .in_valid(vc),
    .dividend(c_ma), .divisor(c_mb),
    .side_in({c_up, c_x1[29:0], c_neg, c_fault}),
    .out_valid(d1_v), .quotient(d1_q), .side_out(d1_side)
  );

  // x1 fits 18 signed bits, so 30 bits of it keep its value
  logic [31:0] d1_x1, d1_up;
  assign d1_x1 = {{2{d1_side[31]}}, d1_side[31:2]};
  assign d1_up = d1_side[63:32];

  logic        vd, d_fault;
  logic [31:0] d_b5, d_up;
  logic        ve, e_fault;
  logic [31:0] e_t, e_b6, e_up;
  logic        vf, f_fault;
  logic [31:0] f_t, f_sqp, f_p2, f_p3, f_up;
  logic        vg, g_fault;
  logic [31:0] g_t, g_sq, g_x2a, g_x1c, g_up;
  logic        vh, h_fault;
  logic [31:0] h_t, h_mb2, h_mb1, h_x2a, h_x1c, h_up;
  logic        vi, i_fault;
  logic [31:0] i_t, i_b3, i_xs, i_up;
  logic        vj, j_fault;
  logic [31:0] j_t, j_b4p, j_dp;
  logic        vk, k_fault;
  logic [31:0] k_t, k_b4, k_b7;
  logic        vl, l_fault, l_big;
  logic [31:0] l_t, l_num, l_b4;

  logic [31:0] ix3, ib3s, ix3b;
  assign ix3  = asr(h_mb2, 11) + h_x2a;
  assign ib3s = ((32'(ac1 << 2) + ix3) << oss) + 32'd2;
  assign ix3b = asr(h_x1c + asr(h_mb1, 16) + 32'd2, 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0; ve <= 1'b0; vf <= 1'b0; vg <= 1'b0; vh <= 1'b0;
      vi <= 1'b0; vj <= 1'b0; vk <= 1'b0; vl <= 1'b0;
    end else if (en) begin
      vd <= d1_v; ve <= vd; vf <= ve; vg <= vf; vh <= vg;
      vi <= vh; vj <= vi; vk <= vj; vl <= vk;
    end
    if (en) begin
      d_b5    <= d1_x1 + (d1_side[1] ? 32'd0 - d1_q : d1_q);
      d_fault <= d1_side[0];
      d_up    <= d1_up;
      e_t     <= asr(d_b5 + 32'd8, 4);
      e_b6    <= d_b5 - 32'd4000;
      e_fault <= d_fault;
      e_up    <= d_up;
      f_sqp   <= 32'(e_b6 * e_b6);
      f_p2    <= 32'(ac2 * e_b6);
      f_p3    <= 32'(ac3 * e_b6);
      f_t     <= e_t;
      f_fault <= e_fault;
      f_up    <= e_up;
      g_sq    <= asr(f_sqp, 12);
      g_x2a   <= asr(f_p2, 11);
      g_x1c   <= asr(f_p3, 13);
      g_t     <= f_t;
      g_fault <= f_fault;
      g_up    <= f_up;
      h_mb2   <= 32'(b2 * g_sq);
      h_mb1   <= 32'(b1 * g_sq);
      h_x2a   <= g_x2a;
      h_x1c   <= g_x1c;
      h_t     <= g_t;
      h_fault <= g_fault;
      h_up    <= g_up;
      i_b3    <= asr(ib3s, 2);
      i_xs    <= ix3b + 32'd32768;
      i_t     <= h_t;
      i_fault <= h_fault;
      i_up    <= h_up;
      j_b4p   <= 32'(ac4 * i_xs);
      j_dp    <= i_up - i_b3;
      j_t     <= i_t;
      j_fault <= i_fault;
      k_b4    <= j_b4p >> 15;
      k_b7    <= 32'(j_dp * (32'd50000 >> oss));
      k_t     <= j_t;
      k_fault <= j_fault || (j_b4p >> 15) == 32'd0;
      l_big   <= k_b7[31];
      l_num   <= k_b7[31] ? k_b7 : k_b7 << 1;
      l_b4    <= k_b4;
      l_t     <= k_t;
      l_fault <= k_fault;
    end
  end

  logic              d2_v;
  logic [31:0]       d2_q;
  logic [SIDE_W-1:0] d2_side;

  bcu_udiv u_div_p (
    .clk(clk), .rst(rst), .en(en), .in_valid(vl),
    .dividend(l_num), .divisor(l_b4),
    .side_in({30'd0, l_t, l_big, l_fault}),
    .out_valid(d2_v), .quotient(d2_q), .side_out(d2_side)
  );

  logic        vm, m_fault;
  logic [31:0] m_p, m_t;
  logic        vn, n_fault;
  logic [31:0] n_p, n_t, n_sq8, n_m7;
  logic        vo, o_fault;
  logic [31:0] o_p, o_t, o_x1, o_x2;
  logic [31:0] ms8, pr;
  assign ms8 = asr(m_p, 8);
  assign pr  = o_p + asr(o_x1 + o_x2 + 32'd3791, 4);

  logic [15:0] t_sat;
  logic [19:0] p_sat;
  always_comb begin
    if ($signed(o_t) > 32'sd32767) t_sat = 16'h7fff;
    else if ($signed(o_t) < -32'sd32768) t_sat = 16'h8000;
    else t_sat = o_t[15:0];
    if (pr[31]) p_sat = '0;
    else if (pr > 32'd1048575) p_sat = 20'hfffff;
    else p_sat = pr[19:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0; vn <= 1'b0; vo <= 1'b0; m_tvalid <= 1'b0;
    end else if (en) begin
      vm <= d2_v; vn <= vm; vo <= vn; m_tvalid <= vo;
    end
    if (en) begin
      m_p     <= d2_side[1] ? d2_q << 1 : d2_q;
      m_t     <= d2_side[33:2];
      m_fault <= d2_side[0];
      n_sq8   <= 32'(ms8 * ms8);
      n_m7    <= 32'((32'd0 - 32'd7357) * m_p);
      n_p     <= m_p;
      n_t     <= m_t;
      n_fault <= m_fault;
      o_x1    <= asr(32'(n_sq8 * 32'd3038), 16);
      o_x2    <= asr(n_m7, 16);
      o_p     <= n_p;
      o_t     <= n_t;
      o_fault <= n_fault;
      if (o_fault) m_tdata <= {3'd0, 1'b1, 20'd0, 16'd0};
      else m_tdata <= {3'd0, 1'b0, p_sat, t_sat};
    end
  end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import bcu_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  typedef struct packed {
    logic [15:0] temp;
    logic [19:0] pres;
    logic        fault;
  } sample_t;

  logic [63:0] cal_a, cal_b;
  logic [31:0] cal_c;
  logic [1:0]  oss_set;

  int errors = 0;
  int n_fault = 0;

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sra(logic [31:0] x, int s);
    return $unsigned($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] qdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic sample_t compensate(logic [39:0] w);
    sample_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, dv;
    logic signed [31:0] t, pr;
    ac1 = ext16(cal_a[63:48]); ac2 = ext16(cal_a[47:32]);
    ac3 = ext16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
    ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
    b1 = ext16(cal_b[31:16]); b2 = ext16(cal_b[15:0]);
    mc = ext16(cal_c[31:16]); md = ext16(cal_c[15:0]);
    ut = {16'd0, w[15:0]};
    up = {8'd0, w[23:16], w[31:24], w[39:32]} >> (8 - oss_set);
    r = '{temp: 0, pres: 0, fault: 1'b1};
    x1 = sra((ut - ac6) * ac5, 15);
    dv = x1 + md;
    if (dv == 0) return r;
    x2 = qdiv(mc * 32'd2048, dv);
    b5 = x1 + x2;
    t = $signed(sra(b5 + 8, 4));
    b6 = b5 - 32'd4000;
    sq = sra(b6 * b6, 12);
    x1 = sra(b2 * sq, 11);
    x2 = sra(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = sra(((ac1 * 4 + x3) << oss_set) + 2, 2);
    x1 = sra(ac3 * b6, 13);
    x2 = sra(b1 * sq, 16);
    x3 = sra(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) return r;
    b7 = (up - b3) * (32'd50000 >> oss_set);
    if (!b7[31]) p = (b7 * 2) / b4;
    else p = (b7 / b4) * 2;
    x1 = sra(p, 8) * sra(p, 8);
    x1 = sra(x1 * 32'd3038, 16);
    x2 = sra((32'd0 - 32'd7357) * p, 16);
    pr = $signed(p + sra(x1 + x2 + 32'd3791, 4));
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (pr < 0) pr = 0;
    if (pr > 1048575) pr = 1048575;
    r.temp = t[15:0];
    r.pres = pr[19:0];
    r.fault = 1'b0;
    return r;
  endfunction

  class sample_board;
    sample_t pending[$];

    function void note(sample_t s);
      pending.push_back(s);
    endfunction

    function void check(logic [39:0] d);
      sample_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.temp) begin
        $display("%0t: temperature expected %0d got %0d", $time,
                 $signed(e.temp), $signed(d[15:0]));
        errors++;
      end
      if (d[35:16] !== e.pres) begin
        $display("%0t: pressure expected %0d got %0d", $time, e.pres, d[35:16]);
        errors++;
      end
      if (d[36] !== e.fault) begin
        $display("%0t: fault expected %0b got %0b", $time, e.fault, d[36]);
        errors++;
      end
      if (d[39:37] !== 3'b000) begin
        $display("%0t: pad expected 0 got %0b", $time, d[39:37]);
        errors++;
      end
    endfunction
  endclass

  sample_board board = new();

  barometric_compensation_unit dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  bit stall_on = 1;
  always @(posedge clk) begin
    if (m_tvalid && m_tready) board.check(m_tdata);
    if (rst) m_tready <= 1'b0;
    else m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CAL_FIRST:  cal_a = v;
      REG_CAL_SECOND: cal_b = v;
      REG_CAL_LAST:   cal_c = v[31:0];
      default:        oss_set = v[1:0];
    endcase
  endtask

  task automatic send(logic [39:0] w);
    sample_t e;
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    e = compensate(w);
    if (e.fault) n_fault++;
    board.note(e);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_cal(logic [63:0] a, logic [63:0] b, logic [31:0] c, logic [1:0] o);
    write_reg(REG_CAL_FIRST, a);
    write_reg(REG_CAL_SECOND, b);
    write_reg(REG_CAL_LAST, {32'd0, c});
    write_reg(REG_OSS, {62'd0, o});
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [39:0] rnd_word();
    return 40'({$urandom, $urandom});
  endfunction

  // typical datasheet-like calibration with small random perturbation
  function automatic logic [63:0] typ_a();
    return {16'd408 + 16'($urandom_range(0, 8000)), -16'sd72 - 16'($urandom_range(0, 400)),
            -16'sd14383 + 16'($urandom_range(0, 2000)), 16'd32741 + 16'($urandom_range(0, 900))};
  endfunction

  function automatic logic [63:0] typ_b();
    return {16'd32757 - 16'($urandom_range(0, 20000)), 16'd23153 + 16'($urandom_range(0, 9000)),
            16'd6190 + 16'($urandom_range(0, 400)), 16'd4 + 16'($urandom_range(0, 60))};
  endfunction

  function automatic logic [31:0] typ_c();
    return {-16'sd8711 + 16'($urandom_range(0, 2000)), 16'd2868 + 16'($urandom_range(0, 600))};
  endfunction

  function automatic logic [39:0] typ_word();
    return {8'($urandom), 8'($urandom_range(0, 255)), 8'($urandom_range(32'h90, 32'hC0)),
            16'($urandom_range(20000, 34000))};
  endfunction

  int phase;
  initial begin
    rst = 1; s_tvalid = 0; s_tdata = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    cal_a = 0; cal_b = 0; cal_c = 0; oss_set = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset calibration: temperature divisor zero
    send(40'h0); send(40'hFF_FFFF_FFFF);
    drain();

    load_cal({16'd408, -16'sd72, -16'sd14383, 16'd32741},
             {16'd32757, 16'd23153, 16'd6190, 16'd4},
             {-16'sd8711, 16'd2868}, 2'd0);
    send({8'h00, 8'h23, 8'h5D, 16'd27898});
    send({8'h00, 8'h00, 8'h00, 16'd0});
    send({8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
    send({8'hAA, 8'h55, 8'hAA, 16'h8000});
    send({8'h55, 8'hAA, 8'h55, 16'h7FFF});
    drain();
    // zero pressure divisor
    write_reg(REG_CAL_FIRST, {16'd408, -16'sd72, -16'sd14383, 16'd0});
    send({8'h00, 8'h23, 8'h5D, 16'd27898});
    drain();
    // extremes of the calibration words
    load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 2'd3);
    send(40'hFF_FFFF_FFFF); send(40'h00_0000_0000); send({8'h80, 8'h80, 8'h80, 16'h8000});
    drain();
    load_cal(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000, 32'h8000_8000, 2'd1);
    send(40'hFF_FFFF_FFFF); send(40'h00_0000_0001); send({8'h01, 8'h01, 8'h01, 16'h0001});
    drain();
    load_cal(64'h7FFF_7FFF_7FFF_FFFF, 64'hFFFF_0000_7FFF_7FFF, 32'h7FFF_7FFF, 2'd2);
    send(40'hFF_FFFF_FFFF); send(40'h00_0000_0000); send({8'h7F, 8'hFF, 8'hFF, 16'h1234});
    drain();

    for (phase = 0; phase < 12; phase++) begin
      stall_on = (phase % 4 != 3);
      if (phase % 3 == 2) load_cal(rnd64(), rnd64(), $urandom, 2'($urandom));
      else load_cal(typ_a(), typ_b(), typ_c(), 2'(phase % 4));
      repeat (38) begin
        if ($urandom_range(0, 3) == 0) send(rnd_word());
        else send(typ_word());
      end
      drain();
    end

    $display("tb: %0d compensation samples checked, %0d with divide fault,",
             12 * 38 + 17, n_fault);
    $display("tb: over all oversampling settings and random and extreme calibrations");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
